// ----- rtl/tlqp_pkg.sv -----
// Package for the two-link quaternion position block: widths, item types and register codes.
`timescale 1ns / 1ps

package tlqp_pkg;

    // Fixed field widths.
    localparam int QUAT_W      = 16;
    localparam int LEN_W       = 16;
    localparam int POS_WIDTH   = 24;
    localparam int CFG_DATA_W  = 2 * POS_WIDTH;
    localparam int CFG_IDX_W   = 3;

    // Pipeline depth of each part, used for the valid line.
    localparam int LANE_STAGES  = 4;
    localparam int MERGE_STAGES = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X      = 3'd0,
        CFG_START_Y      = 3'd1,
        CFG_START_Z      = 3'd2,
        CFG_ARM_LENGTHS  = 3'd3,
        CFG_BOUNDS_X     = 3'd4,
        CFG_BOUNDS_Y     = 3'd5,
        CFG_BOUNDS_Z     = 3'd6,
        CFG_CLAMP_ENABLE = 3'd7
    } t_cfg_reg;

    // One input item: two quaternions.
    typedef struct packed {
        logic signed [QUAT_W-1:0] first_w;
        logic signed [QUAT_W-1:0] first_i;
        logic signed [QUAT_W-1:0] first_j;
        logic signed [QUAT_W-1:0] first_k;
        logic signed [QUAT_W-1:0] second_w;
        logic signed [QUAT_W-1:0] second_i;
        logic signed [QUAT_W-1:0] second_j;
        logic signed [QUAT_W-1:0] second_k;
    } t_in_item;

    // One result item: end position.
    typedef struct packed {
        logic signed [POS_WIDTH-1:0] end_x;
        logic signed [POS_WIDTH-1:0] end_y;
        logic signed [POS_WIDTH-1:0] end_z;
    } t_out_item;

    // Quaternion handed to one lane.
    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] i;
        logic signed [QUAT_W-1:0] j;
        logic signed [QUAT_W-1:0] k;
    } t_quat;

    // Per-axis settings handed to the merging stage.
    typedef struct packed {
        logic signed [POS_WIDTH-1:0] start;
        logic signed [POS_WIDTH-1:0] lo;
        logic signed [POS_WIDTH-1:0] hi;
    } t_axis_cfg;

endpackage

// ----- rtl/tlqp_lane.sv -----
// One lane: rotates an arm along x by a quaternion and rounds the three components.
`timescale 1ns / 1ps

module tlqp_lane #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  tlqp_pkg::t_quat                      i_quat,
    input  logic [tlqp_pkg::LEN_W-1:0]           i_len,
    output logic [2:0][51-2*QUAT_FRAC_BITS-1:0]  o_arm
);
    import tlqp_pkg::*;

    // Column entries carry 2F fraction bits and reach about 2^32 in magnitude.
    localparam int PROD_W = 51;
    localparam int ARM_W  = PROD_W - 2 * QUAT_FRAC_BITS;
    localparam int C_W    = 2 * QUAT_W + 2;
    localparam int P_W    = 2 * QUAT_W;

    localparam logic signed [C_W-1:0] ONE_C =
        {{(C_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HALF =
        {{(PROD_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS - 1);

    logic signed [P_W-1:0]    r_jj, r_kk, r_ij, r_wk, r_ik, r_wj;
    logic signed [C_W-1:0]    n_c0, n_c1, n_c2;
    logic signed [C_W-1:0]    r_c0, r_c1, r_c2;
    logic signed [LEN_W:0]    len_s;
    logic signed [PROD_W-1:0] r_prod0, r_prod1, r_prod2;
    logic signed [PROD_W-1:0] rnd0, rnd1, rnd2;
    logic [ARM_W-1:0]         r_arm0, r_arm1, r_arm2;

    // Stage 1: the six products of quaternion parts.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_jj <= i_quat.j * i_quat.j;
            r_kk <= i_quat.k * i_quat.k;
            r_ij <= i_quat.i * i_quat.j;
            r_wk <= i_quat.w * i_quat.k;
            r_ik <= i_quat.i * i_quat.k;
            r_wj <= i_quat.w * i_quat.j;
        end
    end

    // Stage 2: first column of the rotation matrix.
    always_comb begin
        n_c0 = ONE_C - ((C_W'(r_jj) + C_W'(r_kk)) <<< 1);
        n_c1 = (C_W'(r_ij) + C_W'(r_wk)) <<< 1;
        n_c2 = (C_W'(r_ik) - C_W'(r_wj)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0 <= n_c0;
            r_c1 <= n_c1;
            r_c2 <= n_c2;
        end
    end

    // Stage 3: scale each entry by the arm length.
    assign len_s = $signed({1'b0, i_len});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod0 <= len_s * r_c0;
            r_prod1 <= len_s * r_c1;
            r_prod2 <= len_s * r_c2;
        end
    end

    // Stage 4: round half up and drop the fraction bits.
    always_comb begin
        rnd0 = r_prod0 + HALF;
        rnd1 = r_prod1 + HALF;
        rnd2 = r_prod2 + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arm0 <= rnd0[PROD_W-1:2*QUAT_FRAC_BITS];
            r_arm1 <= rnd1[PROD_W-1:2*QUAT_FRAC_BITS];
            r_arm2 <= rnd2[PROD_W-1:2*QUAT_FRAC_BITS];
        end
    end

    assign o_arm[0] = r_arm0;
    assign o_arm[1] = r_arm1;
    assign o_arm[2] = r_arm2;

endmodule

// ----- rtl/tlqp_merge.sv -----
// Merging stage: adds both arms to the start point, saturates and applies the bounds.
`timescale 1ns / 1ps

module tlqp_merge #(
    parameter int ARM_W = 23
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [2:0][ARM_W-1:0]                 i_arm_a,
    input  logic [2:0][ARM_W-1:0]                 i_arm_b,
    input  tlqp_pkg::t_axis_cfg [2:0]             i_axis_cfg,
    input  logic                                  i_clamp_en,
    output logic [2:0][tlqp_pkg::POS_WIDTH-1:0]   o_pos
);
    import tlqp_pkg::*;

    localparam int SUM_W = ((ARM_W > POS_WIDTH) ? ARM_W : POS_WIDTH) + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic signed [SUM_W-1:0]     n_sum [3];
    logic signed [SUM_W-1:0]     r_sum [3];
    logic signed [POS_WIDTH-1:0] n_sat [3];
    logic signed [POS_WIDTH-1:0] n_pos [3];
    logic [POS_WIDTH-1:0]        r_pos [3];

    // Exact sum of start point and both arms, one adder chain per axis.
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            n_sum[n] = SUM_W'(i_axis_cfg[n].start)
                     + SUM_W'($signed(i_arm_a[n]))
                     + SUM_W'($signed(i_arm_b[n]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 3; n++) begin
                r_sum[n] <= n_sum[n];
            end
        end
    end

    // Saturate to the position range, then limit to the bounds if enabled.
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            if (r_sum[n] > SAT_HI) begin
                n_sat[n] = POS_MAX;
            end else if (r_sum[n] < SAT_LO) begin
                n_sat[n] = POS_MIN;
            end else begin
                n_sat[n] = r_sum[n][POS_WIDTH-1:0];
            end
            n_pos[n] = n_sat[n];
            if (i_clamp_en) begin
                if (n_sat[n] < i_axis_cfg[n].lo) begin
                    n_pos[n] = i_axis_cfg[n].lo;
                end else if (n_sat[n] > i_axis_cfg[n].hi) begin
                    n_pos[n] = i_axis_cfg[n].hi;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 3; n++) begin
                r_pos[n] <= n_pos[n];
            end
        end
    end

    assign o_pos[0] = r_pos[0];
    assign o_pos[1] = r_pos[1];
    assign o_pos[2] = r_pos[2];

endmodule

// ----- rtl/two_link_quaternion_position_top.sv -----
// An accepted item's result is valid once it reaches the output register.
// Throughput: one item per cycle; four lane stages (products, column, length multiply,
// rounding) and two merge stages (sum, saturate and clamp) all advance together.
// The whole pipeline holds only while the output register is full and stalled.
// Reset (synchronous, active low) empties the pipeline and returns the configuration
// registers to their defaults; the datapath registers are left as they are.
`timescale 1ns / 1ps

module two_link_quaternion_position_top #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tlqp_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tlqp_pkg::t_out_item                o_out_data,
    input  logic                               i_cfg_wr_en,
    input  logic [tlqp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tlqp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tlqp_pkg::*;

    localparam int ARM_W = 51 - 2 * QUAT_FRAC_BITS;
    localparam int LAT   = LANE_STAGES + MERGE_STAGES;

    localparam logic [POS_WIDTH-1:0] BOUND_LO_RST = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic [POS_WIDTH-1:0] BOUND_HI_RST = {1'b0, {(POS_WIDTH-1){1'b1}}};

    t_axis_cfg [2:0]        r_axis_cfg;
    logic [LEN_W-1:0]       r_len_a, r_len_b;
    logic                   r_clamp_en;
    logic [LAT-1:0]         r_valid;
    logic                   advance;
    t_quat                  quat_a, quat_b;
    logic [2:0][ARM_W-1:0]  arm_a, arm_b;
    logic [2:0][POS_WIDTH-1:0] pos;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 3; n++) begin
                r_axis_cfg[n].start <= '0;
                r_axis_cfg[n].lo    <= BOUND_LO_RST;
                r_axis_cfg[n].hi    <= BOUND_HI_RST;
            end
            r_len_a    <= '0;
            r_len_b    <= '0;
            r_clamp_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_START_X: begin
                    r_axis_cfg[0].start <= i_cfg_data[POS_WIDTH-1:0];
                end
                CFG_START_Y: begin
                    r_axis_cfg[1].start <= i_cfg_data[POS_WIDTH-1:0];
                end
                CFG_START_Z: begin
                    r_axis_cfg[2].start <= i_cfg_data[POS_WIDTH-1:0];
                end
                CFG_ARM_LENGTHS: begin
                    r_len_a <= i_cfg_data[LEN_W-1:0];
                    r_len_b <= i_cfg_data[2*LEN_W-1:LEN_W];
                end
                CFG_BOUNDS_X: begin
                    r_axis_cfg[0].lo <= i_cfg_data[POS_WIDTH-1:0];
                    r_axis_cfg[0].hi <= i_cfg_data[2*POS_WIDTH-1:POS_WIDTH];
                end
                CFG_BOUNDS_Y: begin
                    r_axis_cfg[1].lo <= i_cfg_data[POS_WIDTH-1:0];
                    r_axis_cfg[1].hi <= i_cfg_data[2*POS_WIDTH-1:POS_WIDTH];
                end
                CFG_BOUNDS_Z: begin
                    r_axis_cfg[2].lo <= i_cfg_data[POS_WIDTH-1:0];
                    r_axis_cfg[2].hi <= i_cfg_data[2*POS_WIDTH-1:POS_WIDTH];
                end
                CFG_CLAMP_ENABLE: begin
                    r_clamp_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves unless a finished item sits stalled in the output register.
    assign advance    = !(r_valid[LAT-1] && i_out_stall);
    assign o_in_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (advance) begin
            r_valid <= {r_valid[LAT-2:0], i_in_valid};
        end
    end

    // Split the input item into one quaternion per lane.
    assign quat_a = '{w: i_in_data.first_w, i: i_in_data.first_i,
                      j: i_in_data.first_j, k: i_in_data.first_k};
    assign quat_b = '{w: i_in_data.second_w, i: i_in_data.second_i,
                      j: i_in_data.second_j, k: i_in_data.second_k};

    tlqp_lane #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_a (
        .i_clk  (i_clk),
        .i_en   (advance),
        .i_quat (quat_a),
        .i_len  (r_len_a),
        .o_arm  (arm_a)
    );

    tlqp_lane #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_b (
        .i_clk  (i_clk),
        .i_en   (advance),
        .i_quat (quat_b),
        .i_len  (r_len_b),
        .o_arm  (arm_b)
    );

    tlqp_merge #(
        .ARM_W (ARM_W)
    ) u_merge (
        .i_clk      (i_clk),
        .i_en       (advance),
        .i_arm_a    (arm_a),
        .i_arm_b    (arm_b),
        .i_axis_cfg (r_axis_cfg),
        .i_clamp_en (r_clamp_en),
        .o_pos      (pos)
    );

    // The merge stage's last register is the output register.
    assign o_out_valid      = r_valid[LAT-1];
    assign o_out_data.end_x = pos[0];
    assign o_out_data.end_y = pos[1];
    assign o_out_data.end_z = pos[2];

endmodule

// ----- rtl/tlqp_checker.sv -----
// Port-level checks for the two-link quaternion position block, bound to the top level.
`timescale 1ns / 1ps

module tlqp_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  tlqp_pkg::t_out_item   i_out_data
);
    import tlqp_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !i_in_stall;

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result item changed");

    // The input side is held back only by a full, stalled output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> (i_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // An accepted item whose pipeline runs on without a stall is then at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 !i_in_stall ##1 !i_in_stall ##1 !i_in_stall ##1 !i_in_stall
        ##1 !i_in_stall |=> i_out_valid)
        else $error("result item missing after pipeline latency");

    // Reset leaves no result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind two_link_quaternion_position_top tlqp_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// ----- tb/two_link_quaternion_position_top_tb.sv -----
// Self-checking testbench for the two-link quaternion end position block.
`timescale 1ns / 1ps

module two_link_quaternion_position_top_tb;
    import tlqp_pkg::*;

    localparam int     FRAC         = 14;
    localparam longint POS_MAX      = 8388607;
    localparam longint POS_MIN      = -8388608;
    localparam int     LONG_HOLD    = 60;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     CYCLE_LIMIT  = 200000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Local copy of the register file, kept in step with every write.
    logic signed [POS_WIDTH-1:0] mirror_start [3];
    logic signed [POS_WIDTH-1:0] mirror_lo [3];
    logic signed [POS_WIDTH-1:0] mirror_hi [3];
    logic [LEN_W-1:0]            mirror_len1;
    logic [LEN_W-1:0]            mirror_len2;
    logic                        mirror_clamp;

    t_in_item    pending_items [$];
    t_out_item   expected_ends [$];
    int          mismatches    = 0;
    int          send_gap      = 0;
    int          stall_left    = 0;
    int          hold_left     = 0;
    int          holds_asked   = 0;
    int          holds_served  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned cycle_count   = 0;

    two_link_quaternion_position_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Round half up: floor((v + half) / 2^(2F)).
    function automatic longint round_fixed(input longint v);
        return (v + (64'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
    endfunction

    // Rotate the arm (len, 0, 0) by one quaternion using the first rotation column.
    function automatic void rotate_arm(input logic signed [QUAT_W-1:0] w, i, j, k,
                                       input logic [LEN_W-1:0] len,
                                       output longint ax, output longint ay,
                                       output longint az);
        longint lw, li, lj, lk, llen, one;
        lw   = w;
        li   = i;
        lj   = j;
        lk   = k;
        llen = len;
        one  = 64'sd1 <<< (2 * FRAC);
        ax = round_fixed(llen * (one - 2 * (lj * lj + lk * lk)));
        ay = round_fixed(llen * (2 * (li * lj + lw * lk)));
        az = round_fixed(llen * (2 * (li * lk - lw * lj)));
    endfunction

    // Saturate one axis to the position range, then apply the bounds if enabled.
    function automatic logic signed [POS_WIDTH-1:0] settle_axis(
            input longint sum, input logic signed [POS_WIDTH-1:0] lo,
            input logic signed [POS_WIDTH-1:0] hi);
        longint v;
        v = sum;
        if (v > POS_MAX) begin
            v = POS_MAX;
        end else if (v < POS_MIN) begin
            v = POS_MIN;
        end
        if (mirror_clamp) begin
            if (v < lo) begin
                v = lo;
            end else if (v > hi) begin
                v = hi;
            end
        end
        return v[POS_WIDTH-1:0];
    endfunction

    // Expected chain end position for one pair of quaternions.
    function automatic t_out_item predict_end(input t_in_item q);
        longint    a1x, a1y, a1z, a2x, a2y, a2z;
        t_out_item r;
        rotate_arm(q.first_w, q.first_i, q.first_j, q.first_k, mirror_len1, a1x, a1y, a1z);
        rotate_arm(q.second_w, q.second_i, q.second_j, q.second_k, mirror_len2,
                   a2x, a2y, a2z);
        r.end_x = settle_axis(mirror_start[0] + a1x + a2x, mirror_lo[0], mirror_hi[0]);
        r.end_y = settle_axis(mirror_start[1] + a1y + a2y, mirror_lo[1], mirror_hi[1]);
        r.end_z = settle_axis(mirror_start[2] + a1z + a2z, mirror_lo[2], mirror_hi[2]);
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Fill the bits above a register's width with noise; the block must ignore them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int width);
        logic [CFG_DATA_W-1:0] mask;
        mask = (48'd1 << width) - 48'd1;
        return (rand48() & ~mask) | (v & mask);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] bounds_of(input longint lo, input longint hi);
        return {24'(hi), 24'(lo)};
    endfunction

    function automatic t_in_item quat_pair(input int w1, i1, j1, k1, w2, i2, j2, k2);
        t_in_item q;
        q.first_w  = 16'(w1);
        q.first_i  = 16'(i1);
        q.first_j  = 16'(j1);
        q.first_k  = 16'(k1);
        q.second_w = 16'(w2);
        q.second_i = 16'(i2);
        q.second_j = 16'(j2);
        q.second_k = 16'(k2);
        return q;
    endfunction

    // One quaternion part: full range, roughly unit scale, or a corner value.
    function automatic logic signed [QUAT_W-1:0] rand_part();
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'($urandom);
            3, 4:    return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sd0;
                    1:       return 16'sd16384;
                    2:       return -16'sd16384;
                    3:       return 16'sh7FFF;
                    default: return 16'sh8000;
                endcase
            end
        endcase
    endfunction

    // Register write at one clock edge; the local copy is updated as the write is driven.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_START_X:      mirror_start[0] = value[POS_WIDTH-1:0];
            CFG_START_Y:      mirror_start[1] = value[POS_WIDTH-1:0];
            CFG_START_Z:      mirror_start[2] = value[POS_WIDTH-1:0];
            CFG_ARM_LENGTHS: begin
                mirror_len1 = value[15:0];
                mirror_len2 = value[31:16];
            end
            CFG_BOUNDS_X: begin
                mirror_lo[0] = value[23:0];
                mirror_hi[0] = value[47:24];
            end
            CFG_BOUNDS_Y: begin
                mirror_lo[1] = value[23:0];
                mirror_hi[1] = value[47:24];
            end
            CFG_BOUNDS_Z: begin
                mirror_lo[2] = value[23:0];
                mirror_hi[2] = value[47:24];
            end
            CFG_CLAMP_ENABLE: mirror_clamp = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input longint sx, sy, sz, input int len1, len2,
                                 input logic [CFG_DATA_W-1:0] bx, by, bz,
                                 input logic clamp_on);
        write_reg(CFG_START_X, with_junk(48'(sx), POS_WIDTH));
        write_reg(CFG_START_Y, with_junk(48'(sy), POS_WIDTH));
        write_reg(CFG_START_Z, with_junk(48'(sz), POS_WIDTH));
        write_reg(CFG_ARM_LENGTHS, with_junk({16'(len2), 16'(len1)}, 32));
        write_reg(CFG_BOUNDS_X, bx);
        write_reg(CFG_BOUNDS_Y, by);
        write_reg(CFG_BOUNDS_Z, bz);
        write_reg(CFG_CLAMP_ENABLE, with_junk(48'(clamp_on), 1));
    endtask

    // Random register contents; bounds are forced into order half the time, else left in random order.
    task automatic random_setting();
        logic [POS_WIDTH-1:0]  a, b;
        logic [CFG_DATA_W-1:0] bnd [3];
        for (int n = 0; n < 3; n++) begin
            a = 24'($urandom);
            b = 24'($urandom);
            if ($urandom_range(0, 1) == 0 && $signed(a) > $signed(b)) begin
                bnd[n] = {a, b};
            end else begin
                bnd[n] = {b, a};
            end
        end
        write_reg(CFG_START_X, rand48());
        write_reg(CFG_START_Y, rand48());
        write_reg(CFG_START_Z, rand48());
        write_reg(CFG_ARM_LENGTHS, rand48());
        write_reg(CFG_BOUNDS_X, bnd[0]);
        write_reg(CFG_BOUNDS_Y, bnd[1]);
        write_reg(CFG_BOUNDS_Z, bnd[2]);
        write_reg(CFG_CLAMP_ENABLE, rand48());
    endtask

    // Corner quaternions: identity, zero, quarter and half turns, extremes, rounding halves.
    task automatic load_directed();
        pending_items.push_back(quat_pair(16384, 0, 0, 0, 16384, 0, 0, 0));
        pending_items.push_back(quat_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(quat_pair(11585, 0, 0, 11585, 11585, 0, 11585, 0));
        pending_items.push_back(quat_pair(0, 16384, 0, 0, -16384, 0, 0, 0));
        pending_items.push_back(quat_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        pending_items.push_back(quat_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_items.push_back(quat_pair(-32768, 32767, -32768, 32767,
                                          32767, -32768, 32767, -32768));
        pending_items.push_back(quat_pair(8192, 0, 0, 8192, 8192, 0, 0, -8192));
        pending_items.push_back(quat_pair(8192, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(quat_pair(0, 0, -32768, -32768, 0, 32767, 32767, 0));
        pending_items.push_back(quat_pair(8192, 0, -8192, 0, 0, 8192, 0, 8192));
        pending_items.push_back(quat_pair(21845, -21846, 21845, -21846,
                                          -21846, 21845, -21846, 21845));
    endtask

    task automatic load_random(input int count);
        t_in_item q;
        repeat (count) begin
            q.first_w  = rand_part();
            q.first_i  = rand_part();
            q.first_j  = rand_part();
            q.first_k  = rand_part();
            q.second_w = rand_part();
            q.second_i = rand_part();
            q.second_j = rand_part();
            q.second_k = rand_part();
            pending_items.push_back(q);
        end
    endtask

    // Waits until every pending item is sent and every expected result has come back.
    task automatic drain();
        while (pending_items.size() != 0 || i_in_valid || expected_ends.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: offers items from the pending queue, with bursts of idle cycles.
    always @(posedge i_clk) begin : drive_items
        logic     took;
        logic     next_valid;
        t_in_item next_data;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                expected_ends.push_back(predict_end(i_in_data));
            end
            next_valid = i_in_valid && !took;
            next_data  = i_in_data;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (send_idle_pct != 0 &&
                             $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 7);
                end else if (pending_items.size() != 0) begin
                    next_data  = pending_items.pop_front();
                    next_valid = 1'b1;
                end
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_data;
        end
    end

    // Receiver: checks each accepted result and stalls in bursts or one long hold.
    always @(posedge i_clk) begin : check_ends
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_ends.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, got x %0d y %0d z %0d",
                             $time, o_out_data.end_x, o_out_data.end_y, o_out_data.end_z);
                end else begin
                    want = expected_ends.pop_front();
                    if (o_out_data.end_x !== want.end_x) begin
                        mismatches++;
                        $display("%0t: end_x expected %0d got %0d",
                                 $time, want.end_x, o_out_data.end_x);
                    end
                    if (o_out_data.end_y !== want.end_y) begin
                        mismatches++;
                        $display("%0t: end_y expected %0d got %0d",
                                 $time, want.end_y, o_out_data.end_y);
                    end
                    if (o_out_data.end_z !== want.end_z) begin
                        mismatches++;
                        $display("%0t: end_z expected %0d got %0d",
                                 $time, want.end_z, o_out_data.end_z);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
                stall_left = $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("two_link_quaternion_position_top_tb: errors");
            $finish;
        end
    end

    // Test sequence: reset, directed corners, then phases of random items under chosen and random settings.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tiny arm lengths so that the rounding halves show in the result.
        send_idle_pct = 25;
        recv_idle_pct = 25;
        apply_setting(0, 0, 0, 1, 3, bounds_of(POS_MIN, POS_MAX), bounds_of(POS_MIN, POS_MAX),
                      bounds_of(POS_MIN, POS_MAX), 1'b0);
        load_directed();
        drain();

        // Start point at the extremes and longest arms: the sums saturate.
        apply_setting(POS_MAX, POS_MIN, POS_MAX, 65535, 65535, bounds_of(POS_MIN, POS_MAX),
                      bounds_of(POS_MIN, POS_MAX), bounds_of(POS_MIN, POS_MAX), 1'b0);
        load_directed();
        drain();

        // Narrow bounds with the minimum above the maximum on z, and a long receiver hold.
        send_idle_pct = 10;
        recv_idle_pct = 30;
        apply_setting(-2000, 500, 0, 40000, 30000, bounds_of(-1000, 1000),
                      bounds_of(0, POS_MAX), bounds_of(5, -5), 1'b1);
        holds_asked++;
        load_random(48);
        drain();

        // Zero arm lengths against the extreme bounds.
        apply_setting(POS_MIN, POS_MAX, 0, 0, 0, bounds_of(POS_MAX, POS_MIN),
                      bounds_of(POS_MIN, POS_MIN), bounds_of(POS_MAX, POS_MAX), 1'b1);
        load_random(20);
        drain();

        // Random settings; the last phase runs without any idling.
        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p == 5) ? 0 : $urandom_range(0, 40);
            recv_idle_pct = (p == 5) ? 0 : $urandom_range(0, 40);
            random_setting();
            load_random(50);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_ends.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_ends.size());
        end
        if (mismatches == 0) begin
            $display("two_link_quaternion_position_top_tb: clean");
        end else begin
            $display("two_link_quaternion_position_top_tb: errors");
        end
        $finish;
    end

endmodule

// ----- two_link_quaternion_position_top.f -----
rtl/tlqp_pkg.sv
rtl/tlqp_lane.sv
rtl/tlqp_merge.sv
rtl/two_link_quaternion_position_top.sv
rtl/tlqp_checker.sv
tb/two_link_quaternion_position_top_tb.sv
